>>> sv/spt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spt_pkg;

    localparam int SPI_W = 32;
    localparam int CMD_W = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND        = 2'd0,
        CMD_REMOVE_OLDEST = 2'd1,
        CMD_REMOVE_PAIR   = 2'd2,
        CMD_QUERY         = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef struct packed {
        logic             exec;
        t_cmd             cmd;
        logic [SPI_W-1:0] client;
        logic [SPI_W-1:0] server;
    } t_cell_ctl;

    typedef struct packed {
        logic             valid;
        logic [SPI_W-1:0] client;
        logic [SPI_W-1:0] server;
    } t_link;

endpackage

`default_nettype wire

>>> sv/spt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module spt_cell
    import spt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_prev_valid,
    input  wire logic      i_prev_hit,
    input  wire t_link     i_next,
    output t_link          o_link,
    output logic           o_hit
);

    logic             r_valid;
    logic [SPI_W-1:0] r_client;
    logic [SPI_W-1:0] r_server;
    logic             w_match;
    logic             w_shift;
    logic             w_write;

    // The hit chain marks this cell and every younger one once the oldest match is seen.
    assign w_match = r_valid && (r_client == i_ctl.client) && (r_server == i_ctl.server);
    assign o_hit   = i_prev_hit || w_match;

    assign w_shift = i_ctl.exec && ((i_ctl.cmd == CMD_REMOVE_OLDEST) ||
                     ((i_ctl.cmd == CMD_REMOVE_PAIR) && o_hit));
    assign w_write = i_ctl.exec && (i_ctl.cmd == CMD_APPEND) && !r_valid && i_prev_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_next.valid;
        end else if (w_write) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_client <= i_next.client;
            r_server <= i_next.server;
        end else if (w_write) begin
            r_client <= i_ctl.client;
            r_server <= i_ctl.server;
        end
    end

    assign o_link.valid  = r_valid;
    assign o_link.client = r_client;
    assign o_link.server = r_server;

endmodule

`default_nettype wire

>>> sv/spi_pair_ordered_table_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tuser: command; tdata: client, server SPI
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: status, entry count
//
// One transaction is taken per cycle while m_axis is not stalled; each accepted command
// is registered first, and its result is registered onto m_axis when it executes.
// The row of cells compares every stored pair at once and closes gaps by a single shift.
// Reset clears the fill count and every cell's valid bit; stored pairs are not cleared.
// While a result waits on m_axis, one further command is held and input then stalls.

module spi_pair_ordered_table_top
    import spt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire logic                                           s_axis_tvalid,
    output logic                                                s_axis_tready,
    // Fields from bit 0: client_spi, server_spi.
    input  wire logic [2*SPI_W-1:0]                             s_axis_tdata,
    // Fields from bit 0: command.
    input  wire logic [CMD_W-1:0]                               s_axis_tuser,
    output logic                                                m_axis_tvalid,
    input  wire logic                                           m_axis_tready,
    // Fields from bit 0: status, entry_count.
    output logic [((STATUS_W+$clog2(TABLE_ENTRIES+1)+7)/8)*8-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int OUT_W = ((STATUS_W + CNT_W + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    logic             r_busy;
    t_cmd             r_cmd;
    logic [SPI_W-1:0] r_client;
    logic [SPI_W-1:0] r_server;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_status          r_status;
    t_status          n_status;
    logic             w_exec;
    logic             w_any_hit;
    t_cell_ctl        w_ctl;
    t_link            w_link [TABLE_ENTRIES];
    logic             w_hit  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_valid_vec;

    assign w_exec        = r_busy && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_busy || w_exec;

    assign w_ctl.exec   = w_exec;
    assign w_ctl.cmd    = r_cmd;
    assign w_ctl.client = r_client;
    assign w_ctl.server = r_server;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            logic  w_prev_valid;
            logic  w_prev_hit;
            t_link w_next;

            if (g == 0) begin : g_head
                assign w_prev_valid = 1'b1;
                assign w_prev_hit   = 1'b0;
            end else begin : g_body
                assign w_prev_valid = w_link[g-1].valid;
                assign w_prev_hit   = w_hit[g-1];
            end

            if (g == TABLE_ENTRIES - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_inner
                assign w_next = w_link[g+1];
            end

            spt_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_prev_valid (w_prev_valid),
                .i_prev_hit   (w_prev_hit),
                .i_next       (w_next),
                .o_link       (w_link[g]),
                .o_hit        (w_hit[g])
            );

            assign w_valid_vec[g] = w_link[g].valid;
        end
    endgenerate

    assign w_any_hit = w_hit[TABLE_ENTRIES-1];

    always_comb begin
        n_status = ST_DONE;
        n_count  = r_count;
        case (r_cmd)
            CMD_APPEND: begin
                if (r_count == FULL_COUNT) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_REMOVE_OLDEST: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_REMOVE_PAIR: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (!w_any_hit) begin
                    n_status = ST_MISSING;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (!w_any_hit) begin
                    n_status = ST_MISSING;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_busy <= 1'b1;
            end else if (w_exec) begin
                r_busy <= 1'b0;
            end
            if (w_exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd    <= t_cmd'(s_axis_tuser);
            r_client <= s_axis_tdata[SPI_W-1:0];
            r_server <= s_axis_tdata[2*SPI_W-1:SPI_W];
        end
        if (w_exec) begin
            r_status <= n_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_count, r_status});

    // The fill count never passes the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("fill count above table size");

    // The valid cells always number exactly the fill count.
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_count))
        else $error("valid cells disagree with fill count");

    // Every executed command leaves a result on the output.
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> m_axis_tvalid)
        else $error("executed command produced no result");

    // A full report is only ever given with a full table.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_status == ST_FULL)) |-> (r_count == FULL_COUNT))
        else $error("full status with table not full");

endmodule

`default_nettype wire

>>> tb/tb_spi_pair_ordered_table_top.sv
`timescale 1ns / 1ps

module tb_spi_pair_ordered_table_top;
    import spt_pkg::*;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RESP_W = ((STATUS_W + CNT_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1725;
    localparam int POOL_SIZE = 8;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        t_cmd             cmd;
        logic [SPI_W-1:0] client;
        logic [SPI_W-1:0] server;
    } t_pair_cmd;

    typedef struct {
        t_status          status;
        logic [CNT_W-1:0] count;
    } t_pair_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [2*SPI_W-1:0]   s_axis_tdata = '0;
    logic [CMD_W-1:0]     s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [RESP_W-1:0]    m_axis_tdata;

    t_pair_cmd    cmd_backlog[$];
    t_pair_result result_due[$];
    t_pair_cmd    offered;

    logic [SPI_W-1:0] shadow_client[DEPTH];
    logic [SPI_W-1:0] shadow_server[DEPTH];
    int               shadow_fill = 0;

    logic [SPI_W-1:0] client_pool[POOL_SIZE];
    logic [SPI_W-1:0] server_pool[POOL_SIZE];

    int total_cmds = 0;
    int issued = 0;
    int accepted = 0;
    int checked = 0;
    int errors = 0;
    int stall_phase = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    int status_seen[4] = '{0, 0, 0, 0};
    int peak_fill = 0;

    spi_pair_ordered_table_top #(
        .TABLE_ENTRIES(DEPTH)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic t_pair_result apply_table_cmd(t_pair_cmd c);
        t_pair_result r;
        int hit;
        int drop_pos;
        r.status = ST_DONE;
        hit = -1;
        drop_pos = -1;
        for (int i = 0; i < shadow_fill; i++) begin
            if (hit < 0 && shadow_client[i] == c.client && shadow_server[i] == c.server) begin
                hit = i;
            end
        end
        case (c.cmd)
            CMD_APPEND: begin
                if (shadow_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_client[shadow_fill] = c.client;
                    shadow_server[shadow_fill] = c.server;
                    shadow_fill++;
                end
            end
            CMD_REMOVE_OLDEST: begin
                if (shadow_fill == 0) r.status = ST_EMPTY;
                else drop_pos = 0;
            end
            CMD_REMOVE_PAIR: begin
                if (shadow_fill == 0) r.status = ST_EMPTY;
                else if (hit < 0) r.status = ST_MISSING;
                else drop_pos = hit;
            end
            default: begin
                if (shadow_fill == 0) r.status = ST_EMPTY;
                else if (hit < 0) r.status = ST_MISSING;
            end
        endcase
        if (drop_pos >= 0) begin
            for (int j = drop_pos; j + 1 < shadow_fill; j++) begin
                shadow_client[j] = shadow_client[j + 1];
                shadow_server[j] = shadow_server[j + 1];
            end
            shadow_fill--;
        end
        r.count = shadow_fill[CNT_W-1:0];
        return r;
    endfunction

    function automatic t_pair_cmd make_cmd(t_cmd op, logic [SPI_W-1:0] cl,
                                           logic [SPI_W-1:0] sv);
        t_pair_cmd c;
        c.cmd = op;
        c.client = cl;
        c.server = sv;
        return c;
    endfunction

    function automatic t_pair_cmd random_cmd(bit filling, int pool_pct);
        t_pair_cmd c;
        int roll;
        int k;
        roll = $urandom_range(99);
        if (filling) begin
            c.cmd = (roll < 55) ? CMD_APPEND : (roll < 65) ? CMD_REMOVE_OLDEST :
                    (roll < 80) ? CMD_REMOVE_PAIR : CMD_QUERY;
        end else begin
            c.cmd = (roll < 20) ? CMD_APPEND : (roll < 50) ? CMD_REMOVE_OLDEST :
                    (roll < 75) ? CMD_REMOVE_PAIR : CMD_QUERY;
        end
        if ($urandom_range(99) < pool_pct) begin
            k = $urandom_range(POOL_SIZE - 1);
            c.client = client_pool[k];
            c.server = server_pool[k];
        end else begin
            c.client = $urandom;
            c.server = $urandom;
        end
        return c;
    endfunction

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (cmd_backlog.size() != 0 &&
                $urandom_range(99) >= (stall_phase == 0 ? 37 : stall_phase == 1 ? 68 : 0)) begin
                offered <= cmd_backlog[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= cmd_backlog[0].cmd;
                s_axis_tdata <= {cmd_backlog[0].server, cmd_backlog[0].client};
                cmd_backlog.pop_front();
                issued <= issued + 1;
                stall_phase <= (issued < total_cmds / 3) ? 0 :
                               (issued < 2 * total_cmds / 3) ? 1 : 2;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_phase == 2 && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <=
                $urandom_range(99) >= (stall_phase == 0 ? 68 : stall_phase == 1 ? 37 : 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            result_due.push_back(apply_table_cmd(offered));
            accepted <= accepted + 1;
            if (shadow_fill > peak_fill) peak_fill <= shadow_fill;
        end
    end

    always @(posedge i_clk) begin
        t_pair_result want;
        logic [STATUS_W-1:0] got_status;
        logic [CNT_W-1:0] got_count;
        int bad;
        bad = 0;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_status = m_axis_tdata[STATUS_W-1:0];
            got_count = m_axis_tdata[STATUS_W +: CNT_W];
            if (result_due.size() == 0) begin
                $error("unexpected result: status %0d, entry_count %0d", got_status, got_count);
                bad = bad + 1;
            end else begin
                want = result_due.pop_front();
                status_seen[want.status] <= status_seen[want.status] + 1;
                checked <= checked + 1;
                if (got_status != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got_status);
                    bad = bad + 1;
                end
                if (got_count != want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, got_count);
                    bad = bad + 1;
                end
            end
            if (bad != 0) begin
                errors <= errors + bad;
            end
        end
    end

    initial begin
        logic [SPI_W-1:0] pa;
        logic [SPI_W-1:0] pb;
        pa = 32'h1234_5678;
        pb = 32'h8765_4321;
        for (int k = 0; k < POOL_SIZE; k++) begin
            client_pool[k] = $urandom;
            server_pool[k] = $urandom;
        end
        client_pool[0] = '0;
        server_pool[0] = '0;
        client_pool[1] = '1;
        server_pool[1] = '1;
        client_pool[7] = client_pool[6];

        cmd_backlog.push_back(make_cmd(CMD_QUERY, '0, '0));
        cmd_backlog.push_back(make_cmd(CMD_REMOVE_PAIR, '1, '1));
        cmd_backlog.push_back(make_cmd(CMD_REMOVE_OLDEST, '1, '0));
        cmd_backlog.push_back(make_cmd(CMD_APPEND, '0, '0));
        cmd_backlog.push_back(make_cmd(CMD_APPEND, '1, '1));
        cmd_backlog.push_back(make_cmd(CMD_APPEND, pa, pb));
        cmd_backlog.push_back(make_cmd(CMD_APPEND, pb, pa));
        cmd_backlog.push_back(make_cmd(CMD_APPEND, pa, pb));
        for (int k = 0; k < 11; k++) begin
            cmd_backlog.push_back(make_cmd(CMD_APPEND, $urandom, $urandom));
        end
        cmd_backlog.push_back(make_cmd(CMD_APPEND, '1, '0));
        cmd_backlog.push_back(make_cmd(CMD_QUERY, pa, pb));
        cmd_backlog.push_back(make_cmd(CMD_QUERY, pa, pa));
        cmd_backlog.push_back(make_cmd(CMD_REMOVE_PAIR, pa, pb));
        cmd_backlog.push_back(make_cmd(CMD_REMOVE_PAIR, 32'h1, 32'h2));
        cmd_backlog.push_back(make_cmd(CMD_REMOVE_OLDEST, '0, '1));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            cmd_backlog.push_back(random_cmd(((n / 48) % 2) == 0, 80));
        end
        total_cmds = cmd_backlog.size();

        wait (accepted == total_cmds);
        wait (result_due.size() == 0);
        repeat (20) @(posedge i_clk);
        if (result_due.size() != 0) begin
            $error("%0d results never arrived", result_due.size());
            errors = errors + 1;
        end
        $display("Checked %0d results from %0d commands; peak table fill %0d of %0d.",
                 checked, accepted, peak_fill, DEPTH);
        $display("Status counts: done %0d, full %0d, empty %0d, not found %0d.",
                 status_seen[ST_DONE], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_MISSING]);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
